[hw/rtl/gda_pkg.sv]
package gda_pkg;

  localparam int unsigned YearBits  = 14;
  localparam int unsigned DaysBits  = 16;
  localparam int unsigned MonthBits = 4;
  localparam int unsigned DayBits   = 5;

  // operand width of the shared subtractor, plus one bit for the borrow
  localparam int unsigned SubWidth = ((DaysBits > YearBits) ? DaysBits : YearBits) + 1;

  localparam logic [YearBits-1:0] YearMax  = '1;
  localparam logic [YearBits-1:0] YearOne  = YearBits'(1);
  localparam logic [YearBits-1:0] Cycle400 = YearBits'(400);
  localparam logic [YearBits-1:0] Rem100   = YearBits'(100);
  localparam logic [YearBits-1:0] Rem200   = YearBits'(200);
  localparam logic [YearBits-1:0] Rem300   = YearBits'(300);
  localparam logic [YearBits-1:0] Rem399   = YearBits'(399);

  localparam logic [MonthBits-1:0] MonthJan = MonthBits'(1);
  localparam logic [MonthBits-1:0] MonthFeb = MonthBits'(2);
  localparam logic [MonthBits-1:0] MonthApr = MonthBits'(4);
  localparam logic [MonthBits-1:0] MonthJun = MonthBits'(6);
  localparam logic [MonthBits-1:0] MonthSep = MonthBits'(9);
  localparam logic [MonthBits-1:0] MonthNov = MonthBits'(11);
  localparam logic [MonthBits-1:0] MonthDec = MonthBits'(12);

  localparam logic [DayBits-1:0] DayOne   = DayBits'(1);
  localparam logic [DayBits-1:0] Len28    = DayBits'(28);
  localparam logic [DayBits-1:0] Len29    = DayBits'(29);
  localparam logic [DayBits-1:0] Len30    = DayBits'(30);
  localparam logic [DayBits-1:0] Len31    = DayBits'(31);

  typedef struct packed {
    logic [YearBits-1:0]  start_year;
    logic [MonthBits-1:0] start_month;
    logic [DayBits-1:0]   start_day;
    logic [DaysBits-1:0]  days_to_add;
  } gda_in_t;

  typedef struct packed {
    logic [YearBits-1:0]  end_year;
    logic [MonthBits-1:0] end_month;
    logic [DayBits-1:0]   end_day;
    logic                 year_overflow;
  } gda_out_t;

endpackage

[hw/rtl/gregorian_date_add_days.sv]
// Sequence: the year is reduced mod 400 by repeated subtraction of 400, the day is
//   clamped to the month length, then the walk steps across month boundaries until
//   the remaining days fit, all through a single shared subtractor.
// Throughput: one item at a time; the next input transfer is taken once the walk ends.
// The result sits in an output register, so a new item may start while it waits.
// Reset (rst_ni low, asynchronous) clears the sequencer and output valid.
module gregorian_date_add_days
  import gda_pkg::*;
#(
  parameter int unsigned SUB_WIDTH = SubWidth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gda_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gda_out_t out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMod   = 3'd1;
  localparam logic [2:0] StClamp = 3'd2;
  localparam logic [2:0] StWalk  = 3'd3;

  localparam int unsigned OpW = SUB_WIDTH - 1;

  logic [2:0]           state_q, state_d;
  logic [YearBits-1:0]  yr_q, yr_d;
  logic [YearBits-1:0]  rem_q, rem_d;
  logic [MonthBits-1:0] mo_q, mo_d;
  logic [DayBits-1:0]   dy_q, dy_d;
  logic [DaysBits-1:0]  left_q, left_d;
  logic                 out_valid_q, out_valid_d;
  gda_out_t             out_q, out_d;

  logic [OpW-1:0]     op_a, op_b, diff;
  logic               borrow;
  logic [DayBits-1:0] len, room;
  logic               slot_free;
  logic               in_xfer;

  gda_mlen u_mlen (
    .month_i  (mo_q),
    .rem400_i (rem_q),
    .len_o    (len)
  );

  gda_sub #(.Width(SUB_WIDTH)) u_sub (
    .a_i      (op_a),
    .b_i      (op_b),
    .diff_o   (diff),
    .borrow_o (borrow)
  );

  assign room      = len - dy_q;
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign in_xfer   = in_valid_i && in_ready_o;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      StMod: begin
        op_a[YearBits-1:0] = rem_q;
        op_b[YearBits-1:0] = Cycle400;
      end
      StClamp: begin
        op_a[DayBits-1:0] = dy_q;
        op_b[DayBits:0]   = {1'b0, len} + (DayBits+1)'(1);
      end
      StWalk: begin
        op_a[DaysBits-1:0] = left_q;
        op_b[DayBits-1:0]  = room + DayOne;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    yr_d        = yr_q;
    rem_d       = rem_q;
    mo_d        = mo_q;
    dy_d        = dy_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          yr_d   = (in_data_i.start_year == '0) ? YearOne : in_data_i.start_year;
          rem_d  = yr_d;
          mo_d   = in_data_i.start_month;
          if (in_data_i.start_month == '0) mo_d = MonthJan;
          if (in_data_i.start_month > MonthDec) mo_d = MonthDec;
          dy_d   = (in_data_i.start_day == '0) ? DayOne : in_data_i.start_day;
          left_d = in_data_i.days_to_add;
          state_d = StMod;
        end
      end
      StMod: begin
        if (borrow) begin
          state_d = StClamp;
        end else begin
          rem_d = diff[YearBits-1:0];
        end
      end
      StClamp: begin
        if (!borrow) dy_d = len;
        state_d = StWalk;
      end
      StWalk: begin
        if (borrow) begin
          // remaining days fit in this month
          if (slot_free) begin
            out_d.end_year      = yr_q;
            out_d.end_month     = mo_q;
            out_d.end_day       = dy_q + left_q[DayBits-1:0];
            out_d.year_overflow = 1'b0;
            out_valid_d         = 1'b1;
            state_d             = StIdle;
          end
        end else if ((mo_q == MonthDec) && (yr_q == YearMax)) begin
          if (slot_free) begin
            out_d.end_year      = YearMax;
            out_d.end_month     = MonthDec;
            out_d.end_day       = Len31;
            out_d.year_overflow = 1'b1;
            out_valid_d         = 1'b1;
            state_d             = StIdle;
          end
        end else begin
          left_d = diff[DaysBits-1:0];
          dy_d   = DayOne;
          if (mo_q == MonthDec) begin
            mo_d  = MonthJan;
            yr_d  = yr_q + YearOne;
            rem_d = (rem_q == Rem399) ? '0 : rem_q + YearOne;
          end else begin
            mo_d = mo_q + MonthBits'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    yr_q   <= yr_d;
    rem_q  <= rem_d;
    mo_q   <= mo_d;
    dy_q   <= dy_d;
    left_q <= left_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_xfer_starts_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StMod))
    else $error("input transfer did not start year reduction");

  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (rem_q < Cycle400))
    else $error("year remainder not reduced below 400 during walk");

  a_day_in_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> ((dy_q != '0) && (dy_q <= len)))
    else $error("day outside month during walk");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.year_overflow) |->
      ((out_q.end_year == YearMax) && (out_q.end_month == MonthDec) &&
       (out_q.end_day == Len31)))
    else $error("overflow result not saturated");

endmodule

[hw/rtl/gda_sub.sv]
module gda_sub
  import gda_pkg::*;
#(
  parameter int unsigned Width = SubWidth
) (
  input  logic [Width-2:0] a_i,
  input  logic [Width-2:0] b_i,
  output logic [Width-2:0] diff_o,
  output logic             borrow_o
);

  logic [Width-1:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[Width-2:0];
  assign borrow_o = full[Width-1];

endmodule

[hw/rtl/gda_mlen.sv]
module gda_mlen
  import gda_pkg::*;
(
  input  logic [MonthBits-1:0] month_i,
  input  logic [YearBits-1:0]  rem400_i,
  output logic [DayBits-1:0]   len_o
);

  logic leap;

  // year mod 4 equals rem400 mod 4 since 4 divides 400
  assign leap = (rem400_i == '0) ||
                ((rem400_i != Rem100) && (rem400_i != Rem200) && (rem400_i != Rem300) &&
                 (rem400_i[1:0] == 2'b00));

  always_comb begin
    case (month_i)
      MonthApr, MonthJun, MonthSep, MonthNov: len_o = Len30;
      MonthFeb: len_o = leap ? Len29 : Len28;
      default: len_o = Len31;
    endcase
  end

endmodule

[tb/sv/gda_date_checker.sv]
`timescale 1ns / 1ps

module gda_date_checker
  import gda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  gda_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  gda_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  gda_out_t expected_dates[$];
  int       mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  function automatic bit is_leap_year(int unsigned yr);
    if (yr % 400 == 0) return 1'b1;
    if (yr % 100 == 0) return 1'b0;
    return (yr % 4 == 0);
  endfunction

  function automatic int unsigned days_of_month(int unsigned yr, int unsigned mo);
    case (mo)
      MonthApr, MonthJun, MonthSep, MonthNov: return 30;
      MonthFeb: return is_leap_year(yr) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic gda_out_t predict_end_date(gda_in_t req);
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned left;
    int unsigned room;
    int unsigned year_top;
    logic        ovf;
    gda_out_t    res;
    yr       = 32'(req.start_year);
    mo       = 32'(req.start_month);
    dy       = 32'(req.start_day);
    left     = 32'(req.days_to_add);
    year_top = 32'(YearMax);
    ovf      = 1'b0;
    if (yr == 0) yr = 1;
    if (mo == 0) mo = 32'(MonthJan);
    if (mo > MonthDec) mo = 32'(MonthDec);
    if (dy == 0) dy = 1;
    if (dy > days_of_month(yr, mo)) dy = days_of_month(yr, mo);
    while (left > 0) begin
      room = days_of_month(yr, mo) - dy;
      if (left <= room) begin
        dy   = dy + left;
        left = 0;
      end else begin
        // rolling over to the 1st uses up one day
        left = left - (room + 1);
        dy   = 1;
        mo   = mo + 1;
        if (mo > MonthDec) begin
          mo = 32'(MonthJan);
          if (yr >= year_top) begin
            ovf  = 1'b1;
            yr   = year_top;
            mo   = 32'(MonthDec);
            dy   = 31;
            left = 0;
          end else begin
            yr = yr + 1;
          end
        end
      end
    end
    res.end_year      = yr[YearBits-1:0];
    res.end_month     = mo[MonthBits-1:0];
    res.end_day       = dy[DayBits-1:0];
    res.year_overflow = ovf;
    return res;
  endfunction

  task automatic note_failure(string what, gda_out_t want, gda_out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %0d-%0d-%0d ovf=%0b, got %0d-%0d-%0d ovf=%0b", $realtime,
               what, want.end_year, want.end_month, want.end_day, want.year_overflow,
               got.end_year, got.end_month, got.end_day, got.year_overflow);
  endtask

  always @(posedge clk_i) begin : watch
    gda_out_t want;
    if (!rst_ni) begin
      expected_dates.delete();
    end else begin
      if (in_valid_i && in_ready_i) expected_dates.push_back(predict_end_date(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          want = '0;
          note_failure("unexpected result", want, out_data_i);
        end else begin
          want = expected_dates.pop_front();
          if (out_data_i.end_year !== want.end_year ||
              out_data_i.end_month !== want.end_month ||
              out_data_i.end_day !== want.end_day ||
              out_data_i.year_overflow !== want.year_overflow)
            note_failure("date mismatch", want, out_data_i);
        end
      end
    end
    pending_o <= expected_dates.size();
  end

endmodule

[tb/sv/tb_gregorian_date_add_days.sv]
`timescale 1ns / 1ps

module tb_gregorian_date_add_days
  import gda_pkg::*;
;

  localparam int NumRandom = 250;
  localparam int CalmTail  = 40;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  gda_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  gda_out_t out_data;
  int       fail_count;
  int       pending;
  bit       idle_on;

  gregorian_date_add_days uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  gda_date_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("[gregorian_date_add_days] ERROR");
    $finish;
  end

  // receiver back-pressure in random bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_date(int unsigned yr, int unsigned mo, int unsigned dy, int unsigned n);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_data.start_year   <= yr[YearBits-1:0];
    in_data.start_month  <= mo[MonthBits-1:0];
    in_data.start_day    <= dy[DayBits-1:0];
    in_data.days_to_add  <= n[DaysBits-1:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random_date;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // raw field noise, out-of-range months and days included
      yr = $urandom;
      mo = $urandom;
      dy = $urandom;
      n  = $urandom;
    end else begin
      if (pick < 20) yr = 100 * $urandom_range(1, 163);
      else if (pick < 35) yr = $urandom_range(YearMax - 300, YearMax);
      else yr = $urandom_range(1, YearMax);
      mo = $urandom_range(1, 12);
      dy = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = $urandom_range(0, 400);
        6, 7, 8:          n = $urandom_range(0, 5000);
        default:          n = $urandom_range(0, 65535);
      endcase
    end
    send_date(yr, mo, dy, n);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    idle_on  = 1'b0;
    rst_n    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n   = 1'b1;
    idle_on = 1'b1;
    @(negedge clk);

    send_date(1, 1, 1, 0);
    send_date(0, 1, 1, 0);             // year zero
    send_date(2023, 0, 15, 10);        // month zero
    send_date(2023, 13, 5, 40);        // month above December
    send_date(2023, 15, 31, 1);
    send_date(2023, 6, 0, 30);         // day zero
    send_date(2023, 2, 31, 1);         // day past end of February
    send_date(2000, 2, 30, 0);         // leap by 400
    send_date(1900, 2, 28, 1);         // century, not leap
    send_date(2024, 2, 28, 1);
    send_date(2100, 2, 29, 0);
    send_date(2023, 4, 31, 1);
    send_date(2023, 1, 31, 1);
    send_date(2023, 12, 31, 1);
    send_date(1, 1, 1, 65535);
    send_date(YearMax, 12, 31, 0);
    send_date(YearMax, 12, 31, 1);     // year overflow
    send_date(YearMax, 1, 1, 364);
    send_date(YearMax, 1, 1, 365);
    send_date(16300, 6, 15, 65535);
    send_date(YearMax, 15, 31, 65535);
    send_date(0, 0, 0, 0);
    send_date(8191, 7, 31, 65535);
    drain();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 60) idle_on = 1'b0;
      if (i == 90) idle_on = 1'b1;
      if (i == 130) drain();
      if (i == NumRandom - CalmTail) idle_on = 1'b0;
      send_random_date();
    end
    drain();
    repeat (50) @(negedge clk);

    if (fail_count == 0) begin
      $display("[gregorian_date_add_days] OK");
    end else begin
      $display("[gregorian_date_add_days] ERROR");
    end
    $finish;
  end

endmodule
